// ----- hdl/msas_pkg.sv -----
// Shared types and constants for the multi-slot alarm scheduler.
package msas_pkg;
	localparam int SLOTS     = 16;
	localparam int SLOT_BITS = 4;
	localparam int TIME_BITS = 32;
	localparam int DAY_SECS  = 60 * 60 * 24;

	typedef logic [TIME_BITS-1:0] time_t;

	localparam logic [2:0] FN_TICK   = 3'd0;
	localparam logic [2:0] FN_ADD    = 3'd1;
	localparam logic [2:0] FN_REMOVE = 3'd2;
	localparam logic [2:0] FN_MODIFY = 3'd3;
	localparam logic [2:0] FN_SHIFT  = 3'd4;
	localparam logic [2:0] FN_BAD    = 3'd7;

	localparam logic [2:0] PH_EMPTY      = 3'd0;
	localparam logic [2:0] PH_SCHED      = 3'd1;
	localparam logic [2:0] PH_ANNOUNCED  = 3'd2;
	localparam logic [2:0] PH_RUNNING    = 3'd3;
	localparam logic [2:0] PH_FINISHED   = 3'd4;
	localparam logic [2:0] PH_TERMINATED = 3'd5;

	localparam logic [2:0] NT_DONE     = 3'd0;
	localparam logic [2:0] NT_ANNOUNCE = 3'd1;
	localparam logic [2:0] NT_START    = 3'd2;
	localparam logic [2:0] NT_STOP     = 3'd3;
	localparam logic [2:0] NT_ACCEPT   = 3'd4;
	localparam logic [2:0] NT_REJECT   = 3'd5;

	// one command word passed from front to back
	typedef struct packed {
		logic [2:0]           func;
		logic [SLOT_BITS-1:0] slot;
		time_t                now_time;
		time_t                announce_time;
		time_t                alarm_time;
		time_t                stop_time;
		logic [2:0]           repeat_mode;
		logic [2:0]           event_type;
	} cmd_t;

	// one result word
	typedef struct packed {
		logic [2:0]           notice;
		logic [SLOT_BITS-1:0] slot;
		logic [2:0]           kind;
		logic                 last;
	} res_t;

	function automatic time_t period_of(input logic [2:0] mode);
		case (mode)
			3'd1:         period_of = time_t'(DAY_SECS);
			3'd2:         period_of = time_t'(DAY_SECS * 7);
			3'd3:         period_of = time_t'(DAY_SECS * 14);
			3'd4, 3'd5:   period_of = time_t'(DAY_SECS * 28);
			default:      period_of = '0;
		endcase
	endfunction
endpackage

// ----- hdl/msas_queue.sv -----
// Two-entry command queue between the front and the back.
module msas_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  msas_pkg::cmd_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output msas_pkg::cmd_t rd_data
);
	import msas_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
		end
	end
endmodule

// ----- hdl/msas_front.sv -----
// Front: takes input words, masks unknown functions, registers them for the queue.
module msas_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  msas_pkg::cmd_t in_cmd,
	output logic           q_valid,
	input  logic           q_ready,
	output msas_pkg::cmd_t q_cmd
);
	import msas_pkg::*;

	logic valid_q;
	cmd_t cmd_q;

	assign in_ready = !valid_q || q_ready;
	assign q_valid  = valid_q;
	assign q_cmd    = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (in_ready) valid_q <= in_valid;
	end

	// unknown functions all become one reject code
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q.slot          <= in_cmd.slot;
			cmd_q.now_time      <= in_cmd.now_time;
			cmd_q.announce_time <= in_cmd.announce_time;
			cmd_q.alarm_time    <= in_cmd.alarm_time;
			cmd_q.stop_time     <= in_cmd.stop_time;
			cmd_q.repeat_mode   <= in_cmd.repeat_mode;
			cmd_q.event_type    <= in_cmd.event_type;
			cmd_q.func          <= (in_cmd.func > FN_SHIFT) ? FN_BAD : in_cmd.func;
		end
	end
endmodule

// ----- hdl/msas_back.sv -----
// Back: slot table and sequencer that executes commands and emits result words.
module msas_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           c_valid,
	output logic           c_ready,
	input  msas_pkg::cmd_t c_cmd,
	output logic           r_valid,
	input  logic           r_ready,
	output msas_pkg::res_t r_res
);
	import msas_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TICK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

	logic [2:0] ph_q [SLOTS];
	time_t      ann_q [SLOTS];
	time_t      alm_q [SLOTS];
	time_t      stp_q [SLOTS];
	logic [2:0] rep_q [SLOTS];
	logic [2:0] kind_q [SLOTS];

	logic [1:0]           st_q;
	logic [SLOT_BITS-1:0] idx_q;
	cmd_t                 cmd_q;
	logic                 ovalid_q;
	res_t                 ores_q;
	logic [2:0]           pend_q;      // notices still to emit for this slot
	logic [2:0]           ph_w;
	logic                 fin_w;

	assign r_valid = ovalid_q;
	assign r_res   = ores_q;
	assign c_ready = st_q == ST_IDLE && !ovalid_q;

	// per-slot tick evaluation for the indexed slot
	logic       a_f, s_f, p_f;
	logic [2:0] p0, p1, p2;
	always_comb begin
		p0  = ph_q[idx_q];
		a_f = ann_q[idx_q] != '0 && p0 == PH_SCHED && ann_q[idx_q] <= cmd_q.now_time;
		p1  = a_f ? PH_ANNOUNCED : p0;
		s_f = alm_q[idx_q] != '0 && (p1 == PH_SCHED || p1 == PH_ANNOUNCED)
			&& alm_q[idx_q] <= cmd_q.now_time;
		p2  = s_f ? ((stp_q[idx_q] == '0) ? PH_FINISHED : PH_RUNNING) : p1;
		p_f = stp_q[idx_q] != '0 && p2 == PH_RUNNING && stp_q[idx_q] <= cmd_q.now_time;
		ph_w  = p_f ? PH_FINISHED : p2;
		fin_w = ph_w == PH_FINISHED;
	end

	// first free slot
	logic                 free_f;
	logic [SLOT_BITS-1:0] free_i;
	always_comb begin
		free_f = 1'b0;
		free_i = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (ph_q[i] == PH_EMPTY) begin
				free_f = 1'b1;
				free_i = SLOT_BITS'(i);
			end
		end
	end

	logic tgt_ok;
	assign tgt_ok = ph_q[c_cmd.slot] != PH_EMPTY;

	function automatic time_t bump(input time_t t, input time_t d);
		bump = (t != '0) ? t + d : t;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			ovalid_q <= 1'b0;
			idx_q    <= '0;
			pend_q   <= '0;
			for (int i = 0; i < SLOTS; i++) ph_q[i] <= PH_EMPTY;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (c_valid && c_ready) begin
						cmd_q <= c_cmd;
						case (c_cmd.func)
							FN_TICK: begin
								idx_q <= '0;
								pend_q <= '0;
								st_q <= ST_TICK;
							end
							FN_ADD: begin
								ovalid_q <= 1'b1;
								if (free_f) begin
									ann_q[free_i]  <= c_cmd.announce_time;
									alm_q[free_i]  <= c_cmd.alarm_time;
									stp_q[free_i]  <= c_cmd.stop_time;
									rep_q[free_i]  <= c_cmd.repeat_mode;
									kind_q[free_i] <= c_cmd.event_type;
									ph_q[free_i]   <= PH_SCHED;
									ores_q <= '{NT_ACCEPT, free_i, c_cmd.event_type, 1'b1};
								end else begin
									ores_q <= '{NT_REJECT, SLOT_BITS'(0), 3'd0, 1'b1};
								end
							end
							FN_REMOVE: begin
								ovalid_q <= 1'b1;
								if (tgt_ok) begin
									ph_q[c_cmd.slot] <= PH_TERMINATED;
									if (ph_q[c_cmd.slot] == PH_RUNNING
										&& stp_q[c_cmd.slot] != '0) begin
										ores_q <= '{NT_STOP, c_cmd.slot,
											kind_q[c_cmd.slot], 1'b0};
										st_q <= ST_EMIT;
									end else begin
										ores_q <= '{NT_ACCEPT, c_cmd.slot,
											kind_q[c_cmd.slot], 1'b1};
									end
								end else begin
									ores_q <= '{NT_REJECT, c_cmd.slot, 3'd0, 1'b1};
								end
							end
							FN_MODIFY: begin
								ovalid_q <= 1'b1;
								if (tgt_ok) begin
									ann_q[c_cmd.slot] <= c_cmd.announce_time;
									alm_q[c_cmd.slot] <= c_cmd.alarm_time;
									stp_q[c_cmd.slot] <= c_cmd.stop_time;
									ph_q[c_cmd.slot]  <= PH_SCHED;
									ores_q <= '{NT_ACCEPT, c_cmd.slot, kind_q[c_cmd.slot], 1'b1};
								end else begin
									ores_q <= '{NT_REJECT, c_cmd.slot, 3'd0, 1'b1};
								end
							end
							FN_SHIFT: begin
								ovalid_q <= 1'b1;
								if (tgt_ok) begin
									ann_q[c_cmd.slot] <= bump(ann_q[c_cmd.slot],
										c_cmd.announce_time);
									alm_q[c_cmd.slot] <= bump(alm_q[c_cmd.slot], c_cmd.alarm_time);
									stp_q[c_cmd.slot] <= bump(stp_q[c_cmd.slot], c_cmd.stop_time);
									ph_q[c_cmd.slot]  <= PH_SCHED;
									ores_q <= '{NT_ACCEPT, c_cmd.slot, kind_q[c_cmd.slot], 1'b1};
								end else begin
									ores_q <= '{NT_REJECT, c_cmd.slot, 3'd0, 1'b1};
								end
							end
							default: begin
								ovalid_q <= 1'b1;
								ores_q <= '{NT_REJECT, c_cmd.slot, 3'd0, 1'b1};
							end
						endcase
					end else if (ovalid_q && r_ready) begin
						ovalid_q <= 1'b0;
					end
				end
				// remove: the accept word follows the stop word
				ST_EMIT: begin
					if (!ovalid_q || r_ready) begin
						ovalid_q <= 1'b1;
						ores_q <= '{NT_ACCEPT, cmd_q.slot, kind_q[cmd_q.slot], 1'b1};
						st_q <= ST_IDLE;
					end
				end
				// one slot per visit; each pending notice is emitted on its own
				ST_TICK: begin
					if (!ovalid_q || r_ready) begin
						if (pend_q != 3'd0) begin
							// emit lowest pending notice
							ovalid_q <= 1'b1;
							if (pend_q[0]) begin
								ores_q <= '{NT_ANNOUNCE, idx_q, kind_q[idx_q], 1'b0};
								pend_q <= pend_q & 3'b110;
							end else if (pend_q[1]) begin
								ores_q <= '{NT_START, idx_q, kind_q[idx_q], 1'b0};
								pend_q <= pend_q & 3'b100;
							end else begin
								ores_q <= '{NT_STOP, idx_q, kind_q[idx_q], 1'b0};
								pend_q <= 3'b000;
							end
							if ((pend_q & (pend_q - 3'd1)) == 3'd0) begin
								// final notice of this slot
								if (idx_q == LAST_SLOT) st_q <= ST_DONE;
								else idx_q <= idx_q + 1'b1;
							end
						end else begin
							// commit slot; an empty slot stays empty
							if (fin_w) begin
								if (period_of(rep_q[idx_q]) != '0) begin
									ann_q[idx_q] <= bump(ann_q[idx_q], period_of(rep_q[idx_q]));
									alm_q[idx_q] <= bump(alm_q[idx_q], period_of(rep_q[idx_q]));
									stp_q[idx_q] <= bump(stp_q[idx_q], period_of(rep_q[idx_q]));
									ph_q[idx_q] <= PH_SCHED;
								end else ph_q[idx_q] <= PH_EMPTY;
							end else if (ph_w == PH_TERMINATED) ph_q[idx_q] <= PH_EMPTY;
							else ph_q[idx_q] <= ph_w;
							if (a_f || s_f || p_f) begin
								ovalid_q <= 1'b0;
								pend_q <= {p_f, s_f, a_f};
							end else if (idx_q == LAST_SLOT) begin
								ovalid_q <= 1'b1;
								ores_q <= '{NT_DONE, SLOT_BITS'(0), 3'd0, 1'b1};
								st_q <= ST_IDLE;
							end else begin
								ovalid_q <= 1'b0;
								idx_q <= idx_q + 1'b1;
							end
						end
					end
				end
				// tick done word after the last slot's notices
				ST_DONE: begin
					if (!ovalid_q || r_ready) begin
						ovalid_q <= 1'b1;
						ores_q <= '{NT_DONE, SLOT_BITS'(0), 3'd0, 1'b1};
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/multi_slot_alarm_scheduler_core.sv -----
// Top level of the multi-slot alarm scheduler.
// Commands pass a front register and a two-word queue to the back sequencer, which owns
// the sixteen-slot table. Add, remove, modify and shift register their result word when
// the back takes them, and the back takes a new command once that word has gone; a
// remove that stops a running slot sends one more word. A tick visits slots one a cycle
// through the single slot walker, pausing on a slot to send its notices one word at a
// time, and ends with a done word; output stalls hold the walk. The result register lets
// the next command enter the queue while a word waits to be taken.
module multi_slot_alarm_scheduler_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   func,
	input  logic [3:0]                   slot,
	input  logic [msas_pkg::TIME_BITS-1:0] now_time,
	input  logic [msas_pkg::TIME_BITS-1:0] announce_time,
	input  logic [msas_pkg::TIME_BITS-1:0] alarm_time,
	input  logic [msas_pkg::TIME_BITS-1:0] stop_time,
	input  logic [2:0]                   repeat_mode,
	input  logic [2:0]                   event_type,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   notice,
	output logic [3:0]                   slot_out,
	output logic [2:0]                   type_out,
	output logic                         last
);
	import msas_pkg::*;

	cmd_t in_cmd, f_cmd, q_cmd;
	logic f_valid, f_ready, q_valid, q_ready;
	res_t res;

	assign in_cmd = '{func, slot, now_time, announce_time, alarm_time, stop_time,
		repeat_mode, event_type};

	msas_front u_front (.clk, .arst_n, .in_valid, .in_ready, .in_cmd,
		.q_valid(f_valid), .q_ready(f_ready), .q_cmd(f_cmd));
	msas_queue u_queue (.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_cmd), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd));
	msas_back u_back (.clk, .arst_n, .c_valid(q_valid), .c_ready(q_ready), .c_cmd(q_cmd),
		.r_valid(out_valid), .r_ready(out_ready), .r_res(res));

	assign notice   = res.notice;
	assign slot_out = res.slot;
	assign type_out = res.kind;
	assign last     = res.last;

`ifndef SYNTHESIS
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && notice == NT_DONE |-> last)
		else $error("tick done word without last");
	a_note_notlast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (notice == NT_ANNOUNCE || notice == NT_START) |-> !last)
		else $error("tick notice marked last");
`endif
endmodule
